[src/ipsm_pkg.sv]
// ----------------------------------------------------------------------------
// ipsm_pkg
// Types and constants shared by the idle power state manager modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ipsm_pkg;

    localparam int RAW_W    = 32;
    localparam int SEC_W    = 24;
    localparam int JIT_W    = 16;
    localparam int ACT_W    = 3;
    localparam int MS_PER_S = 1000;
    localparam int THR_W    = SEC_W + 10;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    typedef enum logic [1:0] {
        PS_ACTIVE    = 2'd0,
        PS_LOCKED    = 2'd1,
        PS_OFF       = 2'd2,
        PS_SUSPENDED = 2'd3
    } pstate_t;

    typedef enum logic {
        KIND_POLL   = 1'b0,
        KIND_RESUME = 1'b1
    } kind_t;

    typedef enum logic [2:0] {
        REG_LOCK_S    = 3'd0,
        REG_OFF_S     = 3'd1,
        REG_SUSPEND_S = 3'd2,
        REG_JITTER    = 3'd3,
        REG_ACT_EN    = 3'd4,
        REG_DRY_RUN   = 3'd5,
        REG_INIT_IDLE = 3'd6
    } reg_addr_t;

    localparam logic [SEC_W-1:0] LOCK_S_RST    = SEC_W'(300);
    localparam logic [SEC_W-1:0] OFF_S_RST     = SEC_W'(600);
    localparam logic [SEC_W-1:0] SUSPEND_S_RST = SEC_W'(1800);
    localparam logic [JIT_W-1:0] JITTER_RST    = JIT_W'(500);
    localparam logic [ACT_W-1:0] ACT_EN_RST    = ACT_W'(7);
    localparam logic [RAW_W-1:0] INIT_IDLE_RST = RAW_W'(0);

    localparam logic [THR_W-1:0] LOCK_MS_RST    = THR_W'(300 * MS_PER_S);
    localparam logic [THR_W-1:0] OFF_MS_RST     = THR_W'(600 * MS_PER_S);
    localparam logic [THR_W-1:0] SUSPEND_MS_RST = THR_W'(1800 * MS_PER_S);

    typedef struct packed {
        logic [THR_W-1:0] lock_ms;
        logic [THR_W-1:0] off_ms;
        logic [THR_W-1:0] suspend_ms;
        logic [JIT_W-1:0] jitter_ms;
        logic [ACT_W-1:0] action_enable;
        logic             dry_run;
    } cfg_t;

    typedef struct packed {
        logic             inhibit;
        logic [RAW_W-1:0] idle_ms;
        kind_t            kind;
    } item_t;

    typedef struct packed {
        logic    do_suspend;
        logic    do_off;
        logic    do_lock;
        pstate_t wanted_state;
        pstate_t power_state;
    } result_t;

endpackage

`default_nettype wire

[src/ipsm_cfg.sv]
// ----------------------------------------------------------------------------
// ipsm_cfg
// APB register file. Thresholds are also kept scaled to milliseconds.
// ----------------------------------------------------------------------------
`default_nettype none

module ipsm_cfg (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [ipsm_pkg::ADDR_W-1:0] paddr,
    input  wire logic [ipsm_pkg::DATA_W-1:0] pwdata,
    output logic      [ipsm_pkg::DATA_W-1:0] prdata,
    output logic                           pready,
    output ipsm_pkg::cfg_t                 cfg
);
    import ipsm_pkg::*;

    logic [SEC_W-1:0] lock_s_reg, off_s_reg, suspend_s_reg;
    logic [THR_W-1:0] lock_ms_reg, off_ms_reg, suspend_ms_reg;
    logic [JIT_W-1:0] jitter_reg;
    logic [ACT_W-1:0] act_en_reg;
    logic             dry_run_reg;
    logic [RAW_W-1:0] init_idle_reg;
    logic             wr_en;
    reg_addr_t        addr;
    logic [THR_W-1:0] wdata_ms;

    assign pready   = 1'b1;
    assign wr_en    = psel && penable && pwrite && pready;
    assign addr     = reg_addr_t'(paddr[4:2]);
    assign wdata_ms = THR_W'(pwdata[SEC_W-1:0]) * THR_W'(MS_PER_S);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lock_s_reg     <= LOCK_S_RST;
            off_s_reg      <= OFF_S_RST;
            suspend_s_reg  <= SUSPEND_S_RST;
            lock_ms_reg    <= LOCK_MS_RST;
            off_ms_reg     <= OFF_MS_RST;
            suspend_ms_reg <= SUSPEND_MS_RST;
            jitter_reg     <= JITTER_RST;
            act_en_reg     <= ACT_EN_RST;
            dry_run_reg    <= 1'b0;
            init_idle_reg  <= INIT_IDLE_RST;
        end else if (wr_en) begin
            unique case (addr)
                REG_LOCK_S: begin
                    lock_s_reg  <= pwdata[SEC_W-1:0];
                    lock_ms_reg <= wdata_ms;
                end
                REG_OFF_S: begin
                    off_s_reg  <= pwdata[SEC_W-1:0];
                    off_ms_reg <= wdata_ms;
                end
                REG_SUSPEND_S: begin
                    suspend_s_reg  <= pwdata[SEC_W-1:0];
                    suspend_ms_reg <= wdata_ms;
                end
                REG_JITTER:    jitter_reg    <= pwdata[JIT_W-1:0];
                REG_ACT_EN:    act_en_reg    <= pwdata[ACT_W-1:0];
                REG_DRY_RUN:   dry_run_reg   <= pwdata[0];
                REG_INIT_IDLE: init_idle_reg <= pwdata[RAW_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (addr)
            REG_LOCK_S:    prdata = DATA_W'(lock_s_reg);
            REG_OFF_S:     prdata = DATA_W'(off_s_reg);
            REG_SUSPEND_S: prdata = DATA_W'(suspend_s_reg);
            REG_JITTER:    prdata = DATA_W'(jitter_reg);
            REG_ACT_EN:    prdata = DATA_W'(act_en_reg);
            REG_DRY_RUN:   prdata = DATA_W'(dry_run_reg);
            REG_INIT_IDLE: prdata = DATA_W'(init_idle_reg);
            default:       prdata = '0;
        endcase
    end

    assign cfg.lock_ms       = lock_ms_reg;
    assign cfg.off_ms        = off_ms_reg;
    assign cfg.suspend_ms    = suspend_ms_reg;
    assign cfg.jitter_ms     = jitter_reg;
    assign cfg.action_enable = act_en_reg;
    assign cfg.dry_run       = dry_run_reg;

endmodule

`default_nettype wire

[src/ipsm_core.sv]
// ----------------------------------------------------------------------------
// ipsm_core
// Power state update for one transaction and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ipsm_core (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire ipsm_pkg::cfg_t     cfg,
    input  wire logic               item_valid,
    input  wire ipsm_pkg::item_t    item,
    output logic                    item_ready,
    output logic                    res_valid,
    output ipsm_pkg::result_t       res,
    input  wire logic               res_ready
);
    import ipsm_pkg::*;

    pstate_t          state_reg, state_next, state_mid;
    logic [RAW_W-1:0] baseline_reg, baseline_next;
    logic [RAW_W-1:0] last_raw_reg, last_raw_next;
    logic             last_inh_reg, last_inh_next;
    logic             res_valid_reg;
    result_t          res_reg, res_next;

    logic             step;
    logic             drop;
    logic             rebase;
    logic [RAW_W-1:0] diff;
    logic [THR_W-1:0] eff;
    pstate_t          thr_state, wanted;
    logic [2:0]       pulses;

    assign item_ready = !res_valid_reg || res_ready;
    assign step       = item_valid && item_ready;

    assign drop = ({1'b0, item.idle_ms} + (RAW_W+1)'(cfg.jitter_ms))
                  < {1'b0, last_raw_reg};
    assign diff = item.idle_ms - baseline_reg;

    always_comb begin
        rebase = drop || (item.inhibit != last_inh_reg);
        if (rebase || (item.idle_ms < baseline_reg)) begin
            eff = '0;
        end else begin
            eff = THR_W'(diff);
        end

        if (eff >= cfg.suspend_ms) begin
            thr_state = PS_SUSPENDED;
        end else if (eff >= cfg.off_ms) begin
            thr_state = PS_OFF;
        end else if (eff >= cfg.lock_ms) begin
            thr_state = PS_LOCKED;
        end else begin
            thr_state = PS_ACTIVE;
        end

        state_mid = drop ? PS_ACTIVE : state_reg;

        // stage k+1 is crossed when state_mid <= k < wanted
        pulses        = '0;
        baseline_next = baseline_reg;
        last_raw_next = item.idle_ms;
        last_inh_next = last_inh_reg;
        if (item.kind == KIND_RESUME) begin
            baseline_next = item.idle_ms;
            state_next    = PS_ACTIVE;
            wanted        = PS_ACTIVE;
        end else begin
            baseline_next = rebase ? item.idle_ms : baseline_reg;
            last_inh_next = item.inhibit;
            if (item.inhibit) begin
                wanted = state_mid;
            end else begin
                wanted = thr_state;
                for (int k = 0; k < 3; k++) begin
                    pulses[k] = (2'(k) >= state_mid) && (2'(k) < wanted);
                end
                pulses = pulses & cfg.action_enable & {3{!cfg.dry_run}};
            end
            state_next = wanted;
        end

        res_next.power_state  = state_next;
        res_next.wanted_state = wanted;
        res_next.do_lock      = pulses[0];
        res_next.do_off       = pulses[1];
        res_next.do_suspend   = pulses[2];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= PS_ACTIVE;
            baseline_reg  <= INIT_IDLE_RST;
            last_raw_reg  <= INIT_IDLE_RST;
            last_inh_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            if (step) begin
                state_reg    <= state_next;
                baseline_reg <= baseline_next;
                last_raw_reg <= last_raw_next;
                last_inh_reg <= last_inh_next;
            end
            if (item_ready) begin
                res_valid_reg <= item_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

[src/idle_power_state_manager.sv]
// ----------------------------------------------------------------------------
// idle_power_state_manager
// Idle time driven power state tracker with action pulses.
// ----------------------------------------------------------------------------
// Takes one transaction per clock unless m_tready holds the result back: a poll
// sample or a resume event enters an input register, and the state update runs
// from there into the result register, with the state registers updated as the
// result is written. Thresholds are written in seconds and compared internally
// in milliseconds. The initial idle register is readable but the baseline always
// restarts from its reset value.
`default_nettype none

module idle_power_state_manager (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [39:0]                 s_tdata,  // idle_ms[31:0], inhibit[32]
    input  wire logic                        s_tuser,  // kind
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic      [7:0]                  m_tdata,  // power_state[1:0], wanted_state[3:2],
                                                       // do_lock[4], do_off[5], do_suspend[6]
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [ipsm_pkg::ADDR_W-1:0] paddr,
    input  wire logic [ipsm_pkg::DATA_W-1:0] pwdata,
    output logic      [ipsm_pkg::DATA_W-1:0] prdata,
    output logic                             pready
);
    import ipsm_pkg::*;

    cfg_t    cfg;
    item_t   in_reg;
    logic    in_valid_reg;
    logic    core_ready;
    result_t res;

    ipsm_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign s_tready = !in_valid_reg || core_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_reg.kind    <= kind_t'(s_tuser);
            in_reg.idle_ms <= s_tdata[RAW_W-1:0];
            in_reg.inhibit <= s_tdata[RAW_W];
        end
    end

    ipsm_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .item_valid (in_valid_reg),
        .item       (in_reg),
        .item_ready (core_ready),
        .res_valid  (m_tvalid),
        .res        (res),
        .res_ready  (m_tready)
    );

    assign m_tdata = {1'b0, res};

endmodule

`default_nettype wire

[src/ipsm_chk.sv]
// ----------------------------------------------------------------------------
// ipsm_chk
// Port level checks for the idle power state manager, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ipsm_chk (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata
);

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result transaction changed");

    a_pulse_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[4] || m_tdata[5] || m_tdata[6])
        |-> (m_tdata[1:0] == m_tdata[3:2]) && (m_tdata[1:0] != 2'd0))
        else $error("action pulse without a step up to the wanted state");

    a_deep_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[6] || m_tdata[5])
        |-> (m_tdata[1:0] == 2'd3) || (m_tdata[1:0] == 2'd2 && !m_tdata[6]))
        else $error("off or suspend pulse below its state");

endmodule

bind idle_power_state_manager ipsm_chk u_ipsm_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
